>>> sv/sem_pkg.sv
// Shared types, register indexes and the Sobel kernel arithmetic for the edge stream.
package sem_pkg;

	localparam int CFG_IW     = 2;
	localparam int CFG_DW     = 13;
	localparam int MAX_HEIGHT = 4096;

	localparam logic [CFG_IW-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd2;

	localparam logic [1:0] MODE_G1  = 2'd0;
	localparam logic [1:0] MODE_G2  = 2'd1;
	localparam logic [1:0] MODE_SUM = 2'd2;

	// pending result bits: upper/lower output row, left/right output column
	localparam int RES_UL = 0;
	localparam int RES_UR = 1;
	localparam int RES_LL = 2;
	localparam int RES_LR = 3;

	typedef logic [7:0] pix_t;
	typedef pix_t [2:0][2:0] win_t; // [row: two-up, one-up, current][col: oldest..newest]

	typedef struct packed {
		pix_t        px;
		pix_t        up1;
		pix_t        up2;
		logic [11:0] row;
		logic [9:0]  col;
		logic        top_refl;
		logic        left_refl;
		logic [3:0]  pend;
	} ld_t;

	function automatic logic signed [11:0] ext(input pix_t x);
		return $signed({4'b0000, x});
	endfunction

	function automatic pix_t sat_abs(input logic signed [11:0] g);
		logic [11:0] a;
		a = g[11] ? 12'(-g) : 12'(g);
		return (a > 12'd255) ? 8'd255 : a[7:0];
	endfunction

	function automatic pix_t clamp_pos(input logic signed [11:0] g);
		if (g[11])
			return 8'd0;
		return (g > 12'sd255) ? 8'd255 : g[7:0];
	endfunction

	function automatic pix_t edge_fn(input win_t p, input logic [1:0] mode);
		logic signed [11:0] g1;
		logic signed [11:0] g2;
		logic [8:0]         s;
		pix_t               r;
		g1 = ext(p[2][0]) + (ext(p[2][1]) <<< 1) + ext(p[2][2])
		   - ext(p[0][0]) - (ext(p[0][1]) <<< 1) - ext(p[0][2]);
		g2 = ext(p[0][2]) + (ext(p[1][2]) <<< 1) + ext(p[2][2])
		   - ext(p[0][0]) - (ext(p[1][0]) <<< 1) - ext(p[2][0]);
		s = {1'b0, sat_abs(g1)} + {1'b0, sat_abs(g2)};
		unique case (mode)
			MODE_G1: r = clamp_pos(g1);
			MODE_G2: r = clamp_pos(g2);
			default: r = s[8] ? 8'd255 : s[7:0];
		endcase
		return r;
	endfunction

endpackage

>>> sv/sem_pix_if.sv
// Pixel input channel: valid/ready handshake carrying one grayscale pixel word.
interface sem_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source(output valid, output pixel, input ready);
	modport sink(input valid, input pixel, output ready);
endinterface

>>> sv/sem_res_if.sv
// Result output channel: valid/ready handshake carrying one edge result word.
interface sem_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  edge_value;
	logic [11:0] out_row;
	logic [9:0]  out_col;
	logic        last_of_run;
	logic        frame_end;

	modport source(output valid, output edge_value, output out_row, output out_col,
		output last_of_run, output frame_end, input ready);
	modport sink(input valid, input edge_value, input out_row, input out_col,
		input last_of_run, input frame_end, output ready);
endinterface

>>> sv/sem_line_mem.sv
// Dual line buffer memory: one word per column holds the two-up and one-up pixels.
module sem_line_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_data
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/sem_emit.sv
// 3x3 window, result sequencer and output register: one result word per cycle while the receiver is ready.
module sem_emit import sem_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] mode,
	input  logic       load,
	input  ld_t        ld,
	output logic       can_load,
	sem_res_if.source  results
);

	win_t        win_q;
	logic [3:0]  pend_q;
	logic [11:0] row_s2;
	logic [9:0]  col_s2;
	logic        top_s2;
	logic        left_s2;

	logic        out_valid_q;
	pix_t        edge_q;
	logic [11:0] orow_q;
	logic [9:0]  ocol_q;
	logic        last_q;
	logic        fe_q;

	logic [3:0]       sel;
	logic [3:0]       rest;
	logic             lower;
	logic             right;
	logic             fire;
	logic [2:0][1:0]  rsel;
	logic [2:0][1:0]  csel;
	win_t             p;

	always_comb begin
		sel   = pend_q & (~pend_q + 4'd1);
		rest  = pend_q & ~sel;
		lower = sel[RES_LL] | sel[RES_LR];
		right = sel[RES_UR] | sel[RES_LR];
		rsel[0] = lower ? 2'd1 : (top_s2 ? 2'd2 : 2'd0);
		rsel[1] = lower ? 2'd2 : 2'd1;
		rsel[2] = lower ? 2'd1 : 2'd2;
		csel[0] = right ? 2'd1 : (left_s2 ? 2'd2 : 2'd0);
		csel[1] = right ? 2'd2 : 2'd1;
		csel[2] = right ? 2'd1 : 2'd2;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				p[i][j] = win_q[rsel[i]][csel[j]];
		fire     = (pend_q != 4'd0) && (!out_valid_q || results.ready);
		can_load = (pend_q == 4'd0) || (fire && rest == 4'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
			win_q  <= '0;
		end else if (load) begin
			pend_q <= ld.pend;
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= ld.up2;
			win_q[1][2] <= ld.up1;
			win_q[2][2] <= ld.px;
		end else if (fire) begin
			pend_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_s2  <= ld.row;
			col_s2  <= ld.col;
			top_s2  <= ld.top_refl;
			left_s2 <= ld.left_refl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (results.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			edge_q <= edge_fn(p, mode);
			orow_q <= lower ? row_s2 : row_s2 - 12'd1;
			ocol_q <= right ? col_s2 : col_s2 - 10'd1;
			last_q <= (rest == 4'd0);
			fe_q   <= sel[RES_LR];
		end
	end

	assign results.valid       = out_valid_q;
	assign results.edge_value  = edge_q;
	assign results.out_row     = orow_q;
	assign results.out_col     = ocol_q;
	assign results.last_of_run = last_q;
	assign results.frame_end   = fe_q;

endmodule

>>> sv/sobel_edge_magnitude_stream.sv
// Streaming 3x3 Sobel edge detector top level: counters, line memory and sequencer.
// Usage:
//  pixels  : sink channel, one 8-bit grayscale word per handshake, raster order.
//  results : source channel, edge value with its row/column, last_of_run marks the
//            final word caused by one pixel, frame_end the final word of a frame.
//  cfg_we/cfg_index/cfg_data : register writes (mode, image_width, image_height);
//            a size write restarts the frame. Write only while the block is idle.
// Pixel (r,c) with r,c >= 1 yields output (r-1,c-1); the last column adds (r-1,c),
// the last row repeats both for row r, so the final pixel of a frame yields four words.
// Path: each pixel passes the input register, then the 3x3 window, then the output register.
// Throughput: one pixel per cycle inside a row while results are taken; a pixel that yields
// more than one word stalls the input while the result sequencer feeds one word per cycle out.
// The line memory is read on accept and written back when the pixel enters the
// sequencer; consecutive pixels always address different columns.
// Reset: mode 2, 640x480, counters and window cleared; line memory is not cleared.
// A stalled receiver holds the output register; the sequencer and input back up behind it.
module sobel_edge_magnitude_stream import sem_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	sem_pix_if.sink           pixels,
	sem_res_if.source         results
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WRST = (640 > MAX_WIDTH) ? MAX_WIDTH - 1 : 639;

	logic [1:0]    mode_q;
	logic [CW-1:0] wlast_q;
	logic [11:0]   hlast_q;
	logic [CW-1:0] col_q;
	logic [11:0]   row_q;

	logic          v_s1;
	pix_t          px_s1;
	logic [CW-1:0] col_s1;
	logic [11:0]   row_s1;
	logic          lastc_s1;
	logic          lastr_s1;

	logic          accept;
	logic          move;
	logic          can_load;
	logic [CW-1:0] c_eff;
	logic [11:0]   r_eff;
	logic          last_col;
	logic          last_row;
	logic [CW-1:0] wl_nxt;
	logic [11:0]   hl_nxt;
	logic [10:0]   iw;
	logic [12:0]   ih;
	logic [15:0]   rd_data;
	logic          has_rows;
	logic          has_left;
	ld_t           ld;

	always_comb begin
		iw = cfg_data[10:0];
		ih = cfg_data[12:0];
		if (iw < 11'd2)
			wl_nxt = CW'(1);
		else if (32'(iw) > 32'(MAX_WIDTH))
			wl_nxt = CW'(MAX_WIDTH - 1);
		else
			wl_nxt = CW'(iw - 11'd1);
		if (ih < 13'd2)
			hl_nxt = 12'd1;
		else if (ih > 13'(MAX_HEIGHT))
			hl_nxt = 12'(MAX_HEIGHT - 1);
		else
			hl_nxt = 12'(ih - 13'd1);
	end

	always_comb begin
		c_eff    = (col_q > wlast_q) ? wlast_q : col_q;
		r_eff    = (row_q > hlast_q) ? hlast_q : row_q;
		last_col = (c_eff == wlast_q);
		last_row = (r_eff == hlast_q);
		move     = v_s1 && can_load;
		pixels.ready = !v_s1 || can_load;
		accept   = pixels.valid && pixels.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_SUM;
			wlast_q <= CW'(WRST);
			hlast_q <= 12'd479;
			col_q   <= '0;
			row_q   <= 12'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:
					mode_q <= cfg_data[1:0];
				REG_WIDTH: begin
					wlast_q <= wl_nxt;
					col_q   <= '0;
					row_q   <= 12'd0;
				end
				REG_HEIGHT: begin
					hlast_q <= hl_nxt;
					col_q   <= '0;
					row_q   <= 12'd0;
				end
				default: ;
			endcase
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 12'd0 : r_eff + 12'd1;
			end else begin
				col_q <= c_eff + CW'(1);
				row_q <= r_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (accept)
			v_s1 <= 1'b1;
		else if (move)
			v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1    <= pixels.pixel;
			col_s1   <= c_eff;
			row_s1   <= r_eff;
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
		end
	end

	sem_line_mem #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_mem (
		.clk(clk),
		.rd_en(accept),
		.rd_addr(c_eff),
		.rd_data(rd_data),
		.wr_en(move),
		.wr_addr(col_s1),
		.wr_data({rd_data[7:0], px_s1})
	);

	always_comb begin
		has_rows = (row_s1 != 12'd0);
		has_left = (col_s1 != '0);
		ld.px        = px_s1;
		ld.up1       = rd_data[7:0];
		ld.up2       = rd_data[15:8];
		ld.row       = row_s1;
		ld.col       = 10'(col_s1);
		ld.top_refl  = (row_s1 == 12'd1);
		ld.left_refl = (col_s1 == CW'(1));
		ld.pend[RES_UL] = has_rows && has_left;
		ld.pend[RES_UR] = has_rows && lastc_s1;
		ld.pend[RES_LL] = has_rows && lastr_s1 && has_left;
		ld.pend[RES_LR] = has_rows && lastr_s1 && lastc_s1;
	end

	sem_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.mode(mode_q),
		.load(move),
		.ld(ld),
		.can_load(can_load),
		.results(results)
	);

	a_no_addr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(move && accept) |-> (col_s1 != c_eff))
		else $error("line memory read and write hit the same column");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= wlast_q)
		else $error("column counter beyond row width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= hlast_q)
		else $error("row counter beyond frame height");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.frame_end) |-> results.last_of_run)
		else $error("frame end word not marked last of run");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the Sobel edge stream: random/directed pixels, line-buffer predictor.
module testbench;
	import sem_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 350;

	typedef enum {OP_PIXEL, OP_WRITE, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t             kind;
		logic [7:0]           pixel;
		logic [CFG_IW-1:0]    index;
		logic [CFG_DW-1:0]    data;
		int unsigned          gap;
	} bus_op_t;

	typedef struct packed {
		logic [7:0]  edge_value;
		logic [11:0] out_row;
		logic [9:0]  out_col;
		logic        last_of_run;
		logic        frame_end;
	} edge_word_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	sem_pix_if pixels();
	sem_res_if results();

	sobel_edge_magnitude_stream #(.MAX_WIDTH(MAX_W)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pixels),
		.results  (results)
	);

	bus_op_t    bus_ops[$];
	edge_word_t edge_words_due[$];

	// predictor state
	logic [1:0]  cfg_mode;
	logic [10:0] cfg_width;
	logic [12:0] cfg_height;
	bit [7:0]    hist_far [MAX_W];
	bit [7:0]    hist_near [MAX_W];
	bit [7:0]    nbhd [3][3];
	int unsigned cur_row;
	int unsigned cur_col;

	bit          pix_acc;
	bit          res_acc;
	int unsigned quiet_cycles;
	int unsigned mismatches;
	int unsigned gap_left;
	int unsigned settle;
	int unsigned stall_left;
	int unsigned stretch_left;
	bit          stalls_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int clip_byte(int v);
		if (v < 0)
			return 0;
		return (v > 255) ? 255 : v;
	endfunction

	function automatic logic [7:0] edge_of(int rt, int rm, int rb, int cl, int cm, int cr);
		int p[3][3];
		int rsel[3];
		int csel[3];
		int g1;
		int g2;
		rsel = '{rt, rm, rb};
		csel = '{cl, cm, cr};
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				p[i][j] = nbhd[rsel[i]][csel[j]];
		g1 = p[2][0] + 2 * p[2][1] + p[2][2] - p[0][0] - 2 * p[0][1] - p[0][2];
		g2 = p[0][2] + 2 * p[1][2] + p[2][2] - p[0][0] - 2 * p[1][0] - p[2][0];
		case (cfg_mode)
			MODE_G1: return 8'(clip_byte(g1));
			MODE_G2: return 8'(clip_byte(g2));
			default: return 8'(clip_byte(clip_byte(g1 < 0 ? -g1 : g1)
				+ clip_byte(g2 < 0 ? -g2 : g2)));
		endcase
	endfunction

	function automatic void sobel_predict(logic [7:0] px);
		int         w;
		int         h;
		int         r;
		int         c;
		int         rt;
		int         cl;
		int         n;
		bit         lc;
		bit         lr;
		edge_word_t run_words[4];
		w = (cfg_width < 2) ? 2 : ((cfg_width > MAX_W) ? MAX_W : int'(cfg_width));
		h = (cfg_height < 2) ? 2 : ((cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height));
		r = cur_row;
		c = cur_col;
		if (c >= w)
			c = w - 1;
		if (r >= h)
			r = h - 1;
		lc = (c == w - 1);
		lr = (r == h - 1);
		for (int i = 0; i < 3; i++) begin
			nbhd[i][0] = nbhd[i][1];
			nbhd[i][1] = nbhd[i][2];
		end
		nbhd[0][2] = hist_far[c];
		nbhd[1][2] = hist_near[c];
		nbhd[2][2] = px;
		hist_far[c] = hist_near[c];
		hist_near[c] = px;
		n = 0;
		if (r >= 1) begin
			// reflection: top row of output row 0 and left column of output column 0
			rt = (r == 1) ? 2 : 0;
			cl = (c == 1) ? 2 : 0;
			if (c >= 1) begin
				run_words[n] = '{edge_of(rt, 1, 2, cl, 1, 2), 12'(r - 1), 10'(c - 1), 1'b0, 1'b0};
				n++;
			end
			if (lc) begin
				run_words[n] = '{edge_of(rt, 1, 2, 1, 2, 1), 12'(r - 1), 10'(c), 1'b0, 1'b0};
				n++;
			end
			if (lr) begin
				if (c >= 1) begin
					run_words[n] = '{edge_of(1, 2, 1, cl, 1, 2), 12'(r), 10'(c - 1), 1'b0, 1'b0};
					n++;
				end
				if (lc) begin
					run_words[n] = '{edge_of(1, 2, 1, 1, 2, 1), 12'(r), 10'(c), 1'b0, 1'b1};
					n++;
				end
			end
		end
		if (n > 0)
			run_words[n - 1].last_of_run = 1'b1;
		for (int k = 0; k < n; k++)
			edge_words_due.push_back(run_words[k]);
		if (lc) begin
			cur_col = 0;
			cur_row = lr ? 0 : r + 1;
		end else begin
			cur_col = c + 1;
			cur_row = r;
		end
	endfunction

	// sender: pixels, register writes and drain points, in queue order
	always @(negedge clk) begin : pixel_driver
		logic nv;
		logic nwe;
		nv = 1'b0;
		nwe = 1'b0;
		if (arst_n) begin
			if (pixels.valid && !pix_acc) begin
				nv = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (bus_ops.size() > 0) begin
				case (bus_ops[0].kind)
					OP_PIXEL: begin
						nv = 1'b1;
						pixels.pixel <= bus_ops[0].pixel;
						gap_left = bus_ops[0].gap;
						void'(bus_ops.pop_front());
					end
					default: begin
						if (edge_words_due.size() > 0 || cfg_we)
							settle = 0;
						else
							settle++;
						if (settle >= SETTLE_CYCLES) begin
							if (bus_ops[0].kind == OP_WRITE) begin
								nwe = 1'b1;
								cfg_index <= bus_ops[0].index;
								cfg_data <= bus_ops[0].data;
							end
							settle = 0;
							void'(bus_ops.pop_front());
						end
					end
				endcase
			end
		end
		pixels.valid <= nv;
		cfg_we <= nwe;
	end

	always @(negedge clk) begin : result_receiver
		if (res_acc) begin
			if (stretch_left == 0) begin
				stretch_left = $urandom_range(10, 60);
				stalls_on = ($urandom_range(0, 2) != 0);
			end
			stretch_left--;
			stall_left = stalls_on ? $urandom_range(0, 3) : 0;
		end
		if (stall_left > 0) begin
			stall_left--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_monitor
		edge_word_t got;
		edge_word_t want;
		pix_acc = arst_n && pixels.valid && pixels.ready;
		res_acc = arst_n && results.valid && results.ready;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE: cfg_mode = cfg_data[1:0];
					REG_WIDTH: begin
						cfg_width = cfg_data[10:0];
						cur_row = 0;
						cur_col = 0;
					end
					REG_HEIGHT: begin
						cfg_height = cfg_data[12:0];
						cur_row = 0;
						cur_col = 0;
					end
					default: ;
				endcase
			end
			if (pix_acc)
				sobel_predict(pixels.pixel);
			if (res_acc) begin
				got = '{results.edge_value, results.out_row, results.out_col,
					results.last_of_run, results.frame_end};
				if (edge_words_due.size() == 0) begin
					$error("unexpected result word: row %0d col %0d value %0d",
						got.out_row, got.out_col, got.edge_value);
					mismatches++;
				end else begin
					want = edge_words_due.pop_front();
					if (got.edge_value !== want.edge_value) begin
						$error("edge_value: expected %0d, got %0d", want.edge_value, got.edge_value);
						mismatches++;
					end
					if (got.out_row !== want.out_row) begin
						$error("out_row: expected %0d, got %0d", want.out_row, got.out_row);
						mismatches++;
					end
					if (got.out_col !== want.out_col) begin
						$error("out_col: expected %0d, got %0d", want.out_col, got.out_col);
						mismatches++;
					end
					if (got.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d",
							want.last_of_run, got.last_of_run);
						mismatches++;
					end
					if (got.frame_end !== want.frame_end) begin
						$error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
						mismatches++;
					end
				end
			end
			if (pix_acc || res_acc || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	task automatic queue_write(logic [CFG_IW-1:0] idx, int unsigned val);
		bus_op_t op;
		op = '{OP_WRITE, 8'd0, idx, CFG_DW'(val), 0};
		bus_ops.push_back(op);
	endtask

	task automatic queue_drain();
		bus_op_t op;
		op = '{OP_DRAIN, 8'd0, REG_MODE, '0, 0};
		bus_ops.push_back(op);
	endtask

	// bit i set: pixel i is 255, else 0
	task automatic queue_binary(logic [15:0] mask, int n);
		bus_op_t op;
		for (int i = 0; i < n; i++) begin
			op = '{OP_PIXEL, mask[i] ? 8'd255 : 8'd0, REG_MODE, '0, $urandom_range(0, 3)};
			bus_ops.push_back(op);
		end
	endtask

	task automatic queue_pixels(int n, int style, bit gaps_on);
		bus_op_t op;
		logic [7:0] px;
		for (int i = 0; i < n; i++) begin
			case (style)
				0: px = 8'($urandom_range(0, 255));
				1: px = $urandom_range(0, 1) ? 8'd255 : 8'd0;
				default: px = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
					: 8'($urandom_range(240, 255));
			endcase
			op = '{OP_PIXEL, px, REG_MODE, '0, gaps_on ? $urandom_range(0, 3) : 0};
			bus_ops.push_back(op);
		end
	endtask

	initial begin : stimulus
		int unsigned random_items;
		int unsigned wv;
		int unsigned hv;
		int          eff_w;
		int          eff_h;
		int          frame;
		int          n;
		int          style;
		bit          gaps_on;

		arst_n = 1'b0;
		pixels.valid = 1'b0;
		pixels.pixel = 8'd0;
		results.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		cfg_mode = MODE_SUM;
		cfg_width = 11'd640;
		cfg_height = 13'd480;
		cur_row = 0;
		cur_col = 0;
		pix_acc = 1'b0;
		res_acc = 1'b0;
		quiet_cycles = 0;
		mismatches = 0;
		gap_left = 0;
		settle = 0;
		stall_left = 0;
		stretch_left = 0;
		stalls_on = 1'b0;

		// reset sizes: a few pixels of the first row
		queue_pixels(12, 0, 1'b1);

		// reset mode
		queue_write(REG_WIDTH, 3);
		queue_write(REG_HEIGHT, 2);
		queue_binary(16'b111000, 6);

		queue_write(REG_MODE, MODE_G2);
		queue_write(REG_WIDTH, 2);
		queue_write(REG_HEIGHT, 3);
		queue_binary(16'b011001, 6);

		// unused mode, sizes below range, two frames back to back
		queue_write(REG_MODE, 3);
		queue_write(REG_WIDTH, 0);
		queue_write(REG_HEIGHT, 1);
		queue_binary(16'b10110110, 8);

		// size write in the middle of a frame
		queue_write(REG_MODE, MODE_SUM);
		queue_write(REG_WIDTH, 2);
		queue_write(REG_HEIGHT, 2);
		queue_binary(16'b01, 2);
		queue_write(REG_HEIGHT, 2);
		queue_binary(16'b0110, 4);

		// sizes above range
		queue_write(REG_MODE, MODE_G1);
		queue_write(REG_WIDTH, 1100);
		queue_write(REG_HEIGHT, 5000);
		queue_pixels(10, 0, 1'b0);

		eff_w = MAX_W;
		eff_h = MAX_HEIGHT;
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			queue_write(REG_MODE, $urandom_range(0, 3));
			if ($urandom_range(0, 3) != 0) begin
				wv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
				queue_write(REG_WIDTH, wv);
				eff_w = (wv < 2) ? 2 : wv;
			end
			if ($urandom_range(0, 3) != 0) begin
				hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
				queue_write(REG_HEIGHT, hv);
				eff_h = (hv < 2) ? 2 : hv;
			end
			if (eff_w > 8 || eff_h > 6) begin
				queue_write(REG_WIDTH, 4);
				queue_write(REG_HEIGHT, 3);
				eff_w = 4;
				eff_h = 3;
			end
			frame = eff_w * eff_h;
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, frame - 1);
			else
				n = frame * $urandom_range(1, 2);
			style = $urandom_range(0, 2);
			gaps_on = ($urandom_range(0, 2) != 0);
			if (n > 3 && $urandom_range(0, 3) == 0) begin
				queue_pixels(n / 2, style, gaps_on);
				queue_drain();
				queue_pixels(n - n / 2, style, gaps_on);
			end else begin
				queue_pixels(n, style, gaps_on);
			end
			random_items += n;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (bus_ops.size() > 0 || pixels.valid || edge_words_due.size() > 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && edge_words_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
